### sv/bpt_pkg.sv
package bpt_pkg;

   localparam int TEMP_FRAC_BITS  = 16;
   localparam int PRESS_FRAC_BITS = 6;
   localparam int TLIN_FRAC       = 48;
   localparam int WORK_FRAC       = 16;
   localparam int NUM_STAGES      = 10;
   localparam int CSR_ADDR_WIDTH  = 5;

   localparam logic signed [63:0] S24_MAX   = 64'sd8388607;
   localparam logic signed [63:0] S24_MIN   = -64'sd8388608;
   localparam logic signed [63:0] U24_MAX   = 64'sd16777215;
   localparam logic signed [16:0] P_OFFSET  = 17'sd16384;

   localparam logic [1:0] REG_CALIB_LOW  = 2'd0;
   localparam logic [1:0] REG_CALIB_MID  = 2'd1;
   localparam logic [1:0] REG_CALIB_HIGH = 2'd2;

   typedef struct packed {
      logic [23:0] raw_pressure;
      logic [23:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [23:0] temperature_q16;
      logic [23:0]        pressure_q6;
      logic               saturated;
   } rsp_type;

   function automatic logic signed [63:0] rnd64(input logic signed [63:0] v,
                                                input int unsigned s);
      logic signed [63:0] half;
      half = 64'sd1 <<< (s - 1);
      return (v + half) >>> s;
   endfunction

endpackage

### sv/baro_pressure_temp_compensation_top.sv
// Pipeline: 10 register stages; a result is offered once its input transfer has passed
// through all of them, and it transfers when rsp_ready is high.
// Throughput: one reading per cycle unless rsp_ready stalls the result register; every
// stage holds its own valid bit, so a stall only holds the stages that are full behind it.
// Reset: synchronous; clears all stage valid bits and the three calibration
// words (all calibration registers read as zero until written).
module baro_pressure_temp_compensation_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bpt_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bpt_pkg::rsp_type                    rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bpt_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [63:0]                         pwdata,
   output logic [63:0]                         prdata,
   output logic                                pready
);
   import bpt_pkg::*;

   logic [63:0] cal_low_ff, cal_mid_ff;
   logic [39:0] cal_high_ff;
   logic [1:0]  reg_index;

   assign pready    = 1'b1;
   assign reg_index = paddr[CSR_ADDR_WIDTH-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_low_ff  <= '0;
         cal_mid_ff  <= '0;
         cal_high_ff <= '0;
      end else if (psel && penable && pwrite && pready) begin
         case (reg_index)
            REG_CALIB_LOW:  cal_low_ff  <= pwdata;
            REG_CALIB_MID:  cal_mid_ff  <= pwdata;
            REG_CALIB_HIGH: cal_high_ff <= pwdata[39:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_CALIB_LOW:  prdata = cal_low_ff;
         REG_CALIB_MID:  prdata = cal_mid_ff;
         REG_CALIB_HIGH: prdata = {24'd0, cal_high_ff};
         default:        prdata = '0;
      endcase
   end

   // coefficient decode
   logic [15:0]        cal_t1;
   logic signed [16:0] cal_t2, cal_p1m, cal_p2m, cal_p6, cal_p9;
   logic signed [7:0]  cal_t3, cal_p3, cal_p4, cal_p7, cal_p8, cal_p10, cal_p11;
   logic [15:0]        cal_p5;

   assign cal_t1  = cal_low_ff[15:0];
   assign cal_t2  = $signed({1'b0, cal_low_ff[31:16]});
   assign cal_t3  = $signed(cal_low_ff[39:32]);
   assign cal_p1m = $signed({cal_low_ff[55], cal_low_ff[55:40]}) - P_OFFSET;
   assign cal_p2m = $signed({cal_mid_ff[7], cal_mid_ff[7:0], cal_low_ff[63:56]}) - P_OFFSET;
   assign cal_p3  = $signed(cal_mid_ff[15:8]);
   assign cal_p4  = $signed(cal_mid_ff[23:16]);
   assign cal_p5  = cal_mid_ff[39:24];
   assign cal_p6  = $signed({1'b0, cal_mid_ff[55:40]});
   assign cal_p7  = $signed(cal_mid_ff[63:56]);
   assign cal_p8  = $signed(cal_high_ff[7:0]);
   assign cal_p9  = $signed({cal_high_ff[23], cal_high_ff[23:8]});
   assign cal_p10 = $signed(cal_high_ff[31:24]);
   assign cal_p11 = $signed(cal_high_ff[39:32]);

   // stage flow control
   logic [NUM_STAGES-1:0] v_ff, en;

   always_comb begin
      en[NUM_STAGES-1] = !v_ff[NUM_STAGES-1] || rsp_ready;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = v_ff[NUM_STAGES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= req_valid;
         end
         for (int i = 1; i < NUM_STAGES; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // stage 1: temperature offset
   logic signed [24:0] s1_d_ff, s1_d_in;
   logic [23:0]        s1_up_ff;

   assign s1_d_in = $signed({1'b0, req_payload.raw_temperature}) - $signed({1'b0, cal_t1, 8'h00});

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_d_ff  <= s1_d_in;
         s1_up_ff <= req_payload.raw_pressure;
      end
   end

   // stage 2: products of the offset
   logic signed [41:0] s2_ma_ff, s2_ma_in;
   logic signed [49:0] s2_mb_ff, s2_mb_in;
   logic [23:0]        s2_up_ff;

   assign s2_ma_in = 42'(s1_d_ff) * 42'(cal_t2);
   assign s2_mb_in = 50'(s1_d_ff) * 50'(s1_d_ff);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_ma_ff <= s2_ma_in;
         s2_mb_ff <= s2_mb_in;
         s2_up_ff <= s1_up_ff;
      end
   end

   // stage 3: linearized temperature, Q48
   logic signed [57:0] s3_mb3;
   logic signed [59:0] s3_tlin_ff, s3_tlin_in;
   logic [23:0]        s3_up_ff;

   assign s3_mb3     = 58'(s2_mb_ff) * 58'(cal_t3);
   assign s3_tlin_in = $signed({s2_ma_ff, 18'd0}) + 60'(s3_mb3);

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_tlin_ff <= s3_tlin_in;
         s3_up_ff   <= s2_up_ff;
      end
   end

   // stage 4: round and clamp temperatures
   logic signed [63:0] s4_tw, s4_to;
   logic signed [23:0] s4_t_ff, s4_t_in, s4_tout_ff, s4_tout_in;
   logic               s4_sat_ff, s4_sat_in;
   logic [23:0]        s4_up_ff;

   always_comb begin
      s4_tw      = rnd64(64'(s3_tlin_ff), TLIN_FRAC - WORK_FRAC);
      s4_to      = rnd64(64'(s3_tlin_ff), TLIN_FRAC - TEMP_FRAC_BITS);
      s4_sat_in  = 1'b0;
      s4_t_in    = 24'(s4_tw);
      s4_tout_in = 24'(s4_to);
      if (s4_tw > S24_MAX) begin
         s4_t_in   = 24'(S24_MAX);
         s4_sat_in = 1'b1;
      end else if (s4_tw < S24_MIN) begin
         s4_t_in   = 24'(S24_MIN);
         s4_sat_in = 1'b1;
      end
      if (s4_to > S24_MAX) begin
         s4_tout_in = 24'(S24_MAX);
         s4_sat_in  = 1'b1;
      end else if (s4_to < S24_MIN) begin
         s4_tout_in = 24'(S24_MIN);
         s4_sat_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_t_ff    <= s4_t_in;
         s4_tout_ff <= s4_tout_in;
         s4_sat_ff  <= s4_sat_in;
         s4_up_ff   <= s3_up_ff;
      end
   end

   // stage 5: first-order products
   logic signed [47:0] s5_tsq_ff, s5_tsq_in;
   logic signed [40:0] s5_p6t_ff, s5_p6t_in, s5_p2t_ff, s5_p2t_in;
   logic signed [31:0] s5_p10t_ff, s5_p10t_in;
   logic [47:0]        s5_uu_ff, s5_uu_in;
   logic signed [23:0] s5_t_ff, s5_tout_ff;
   logic               s5_sat_ff;
   logic [23:0]        s5_up_ff;

   assign s5_tsq_in  = 48'(s4_t_ff) * 48'(s4_t_ff);
   assign s5_p6t_in  = 41'(cal_p6) * 41'(s4_t_ff);
   assign s5_p2t_in  = 41'(cal_p2m) * 41'(s4_t_ff);
   assign s5_p10t_in = 32'(cal_p10) * 32'(s4_t_ff);
   assign s5_uu_in   = 48'(s4_up_ff) * 48'(s4_up_ff);

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_tsq_ff  <= s5_tsq_in;
         s5_p6t_ff  <= s5_p6t_in;
         s5_p2t_ff  <= s5_p2t_in;
         s5_p10t_ff <= s5_p10t_in;
         s5_uu_ff   <= s5_uu_in;
         s5_t_ff    <= s4_t_ff;
         s5_tout_ff <= s4_tout_ff;
         s5_sat_ff  <= s4_sat_ff;
         s5_up_ff   <= s4_up_ff;
      end
   end

   // stage 6: second-order products
   logic signed [31:0] s6_t2;
   logic signed [33:0] s6_qbase;
   logic signed [24:0] s5_ups;
   logic signed [48:0] s5_uus;
   logic signed [55:0] s6_tcu_ff, s6_tcu_in;
   logic signed [39:0] s6_p7t2_ff, s6_p7t2_in, s6_p3t2_ff, s6_p3t2_in;
   logic signed [58:0] s6_qa_ff, s6_qa_in;
   logic signed [56:0] s6_k1_ff, s6_k1_in;
   logic signed [34:0] s6_p6r_ff, s6_p6r_in;
   logic signed [35:0] s6_p2r_ff, s6_p2r_in;
   logic signed [23:0] s6_tout_ff;
   logic               s6_sat_ff;
   logic [23:0]        s6_up_ff;

   assign s6_t2      = 32'(rnd64(64'(s5_tsq_ff), 16));
   assign s5_ups     = $signed({1'b0, s5_up_ff});
   assign s5_uus     = $signed({1'b0, s5_uu_ff});
   assign s6_qbase   = 34'($signed({cal_p9, 16'd0})) + 34'(s5_p10t_ff);
   assign s6_tcu_in  = 56'(s6_t2) * 56'(s5_t_ff);
   assign s6_p7t2_in = 40'(cal_p7) * 40'(s6_t2);
   assign s6_p3t2_in = 40'(cal_p3) * 40'(s6_t2);
   assign s6_qa_in   = 59'(s6_qbase) * 59'(s5_ups);
   assign s6_k1_in   = 57'(s5_uus) * 57'(cal_p11);
   assign s6_p6r_in  = 35'(rnd64(64'(s5_p6t_ff), 6));
   assign s6_p2r_in  = 36'(rnd64(64'(s5_p2t_ff), 5));

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_tcu_ff  <= s6_tcu_in;
         s6_p7t2_ff <= s6_p7t2_in;
         s6_p3t2_ff <= s6_p3t2_in;
         s6_qa_ff   <= s6_qa_in;
         s6_k1_ff   <= s6_k1_in;
         s6_p6r_ff  <= s6_p6r_in;
         s6_p2r_ff  <= s6_p2r_in;
         s6_tout_ff <= s5_tout_ff;
         s6_sat_ff  <= s5_sat_ff;
         s6_up_ff   <= s5_up_ff;
      end
   end

   // stage 7: third-order products
   logic signed [39:0] s7_t3;
   logic signed [38:0] s7_q1;
   logic signed [32:0] s7_k2;
   logic signed [24:0] s6_ups;
   logic signed [47:0] s7_p8t3_ff, s7_p8t3_in, s7_p4t3_ff, s7_p4t3_in;
   logic signed [63:0] s7_qb_ff, s7_qb_in;
   logic signed [57:0] s7_kb_ff, s7_kb_in;
   logic signed [31:0] s7_p7r_ff, s7_p7r_in, s7_p3r_ff, s7_p3r_in;
   logic signed [34:0] s7_p6r_ff;
   logic signed [35:0] s7_p2r_ff;
   logic signed [23:0] s7_tout_ff;
   logic               s7_sat_ff;
   logic [23:0]        s7_up_ff;

   assign s7_t3      = 40'(rnd64(64'(s6_tcu_ff), 16));
   assign s7_q1      = 39'(rnd64(64'(s6_qa_ff), 20));
   assign s7_k2      = 33'(rnd64(64'(s6_k1_ff), 24));
   assign s6_ups     = $signed({1'b0, s6_up_ff});
   assign s7_p8t3_in = 48'(cal_p8) * 48'(s7_t3);
   assign s7_p4t3_in = 48'(cal_p4) * 48'(s7_t3);
   assign s7_qb_in   = 64'(s7_q1) * 64'(s6_ups);
   assign s7_kb_in   = 58'(s7_k2) * 58'(s6_ups);
   assign s7_p7r_in  = 32'(rnd64(64'(s6_p7t2_ff), 8));
   assign s7_p3r_in  = 32'(rnd64(64'(s6_p3t2_ff), 8));

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s7_p8t3_ff <= s7_p8t3_in;
         s7_p4t3_ff <= s7_p4t3_in;
         s7_qb_ff   <= s7_qb_in;
         s7_kb_ff   <= s7_kb_in;
         s7_p7r_ff  <= s7_p7r_in;
         s7_p3r_ff  <= s7_p3r_in;
         s7_p6r_ff  <= s6_p6r_ff;
         s7_p2r_ff  <= s6_p2r_ff;
         s7_tout_ff <= s6_tout_ff;
         s7_sat_ff  <= s6_sat_ff;
         s7_up_ff   <= s6_up_ff;
      end
   end

   // stage 8: offset, sensitivity and higher-order terms
   logic signed [41:0] s8_o1_ff, s8_o1_in;
   logic signed [39:0] s8_c_ff, s8_c_in, s8_qk_ff, s8_qk_in;
   logic signed [23:0] s8_tout_ff;
   logic               s8_sat_ff;
   logic [23:0]        s8_up_ff;

   assign s8_o1_in = 42'($signed({1'b0, cal_p5, 19'd0})) + 42'(s7_p6r_ff) + 42'(s7_p7r_ff)
                   + 42'(rnd64(64'(s7_p8t3_ff), 15));
   assign s8_c_in  = 40'($signed({cal_p1m, 20'd0})) + 40'(s7_p2r_ff) + 40'(s7_p3r_ff)
                   + 40'(rnd64(64'(s7_p4t3_ff), 13));
   assign s8_qk_in = 40'(rnd64(s7_qb_ff, 28)) + 40'(rnd64(64'(s7_kb_ff), 25));

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s8_o1_ff   <= s8_o1_in;
         s8_c_ff    <= s8_c_in;
         s8_qk_ff   <= s8_qk_in;
         s8_tout_ff <= s7_tout_ff;
         s8_sat_ff  <= s7_sat_ff;
         s8_up_ff   <= s7_up_ff;
      end
   end

   // stage 9: sensitivity times pressure
   logic signed [24:0] s8_ups;
   logic signed [63:0] s9_cu_ff, s9_cu_in;
   logic signed [41:0] s9_oqk_ff, s9_oqk_in;
   logic signed [23:0] s9_tout_ff;
   logic               s9_sat_ff;

   assign s8_ups    = $signed({1'b0, s8_up_ff});
   assign s9_cu_in  = 64'(s8_c_ff) * 64'(s8_ups);
   assign s9_oqk_in = s8_o1_ff + 42'(s8_qk_ff);

   always_ff @(posedge clock) begin
      if (en[8]) begin
         s9_cu_ff   <= s9_cu_in;
         s9_oqk_ff  <= s9_oqk_in;
         s9_tout_ff <= s8_tout_ff;
         s9_sat_ff  <= s8_sat_ff;
      end
   end

   // stage 10: final sum, clamp, result register
   logic signed [42:0] s10_sum;
   logic signed [63:0] s10_p;
   rsp_type            rsp_ff, rsp_in;

   always_comb begin
      s10_sum                = 43'(s9_oqk_ff) + 43'(rnd64(s9_cu_ff, 24));
      s10_p                  = rnd64(64'(s10_sum), WORK_FRAC - PRESS_FRAC_BITS);
      rsp_in.temperature_q16 = s9_tout_ff;
      rsp_in.saturated       = s9_sat_ff;
      rsp_in.pressure_q6     = 24'(s10_p);
      if (s10_p < 64'sd0) begin
         rsp_in.pressure_q6 = '0;
         rsp_in.saturated   = 1'b1;
      end else if (s10_p > U24_MAX) begin
         rsp_in.pressure_q6 = 24'(U24_MAX);
         rsp_in.saturated   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

### tb/baro_pressure_temp_compensation_top_test.sv
module baro_pressure_temp_compensation_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import bpt_pkg::*;

   localparam int LATENCY     = NUM_STAGES;
   localparam int CYCLE_LIMIT = 400000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_payload;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_payload;
   logic             psel;
   logic             penable;
   logic             pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [63:0]      pwdata;
   logic [63:0]      prdata;
   logic             pready;

   logic [63:0]      calib_low;
   logic [63:0]      calib_mid;
   logic [39:0]      calib_high;

   rsp_type          expected_readings[$];
   int               mismatch_count;
   int               readings_sent;
   int               readings_checked;
   int               saturated_seen;
   int               calib_loads;
   int               cycle_count;
   int               burst_left;
   int               hold_cycles;
   int               stall_mode;
   int               stall_left;

   baro_pressure_temp_compensation_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clip(input longint v, input longint lo, input longint hi,
                                   inout logic hit);
      if (v < lo) begin
         hit = 1'b1;
         return lo;
      end
      if (v > hi) begin
         hit = 1'b1;
         return hi;
      end
      return v;
   endfunction

   function automatic rsp_type compensate(input req_type rd);
      logic [167:0] cal;
      longint       t1, t2c, t3c, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
      longint       up, ut, d, tlin, tout, t, tsq, tcu, o1, c, o2, q, k, pout;
      logic         hit;
      rsp_type      r;
      cal = {calib_high, calib_mid, calib_low};
      t1  = longint'({1'b0, cal[15:0]});
      t2c = longint'({1'b0, cal[31:16]});
      t3c = longint'($signed(cal[39:32]));
      p1  = longint'($signed(cal[55:40]));
      p2  = longint'($signed(cal[71:56]));
      p3  = longint'($signed(cal[79:72]));
      p4  = longint'($signed(cal[87:80]));
      p5  = longint'({1'b0, cal[103:88]});
      p6  = longint'({1'b0, cal[119:104]});
      p7  = longint'($signed(cal[127:120]));
      p8  = longint'($signed(cal[135:128]));
      p9  = longint'($signed(cal[151:136]));
      p10 = longint'($signed(cal[159:152]));
      p11 = longint'($signed(cal[167:160]));
      up  = longint'({1'b0, rd.raw_pressure});
      ut  = longint'({1'b0, rd.raw_temperature});
      hit = 1'b0;
      d    = ut - t1 * 256;
      tlin = d * t2c * (64'sd1 <<< 18) + d * d * t3c;
      tout = clip(round_shift(tlin, TLIN_FRAC - TEMP_FRAC_BITS), S24_MIN, S24_MAX, hit);
      t    = clip(round_shift(tlin, TLIN_FRAC - WORK_FRAC), S24_MIN, S24_MAX, hit);
      tsq  = round_shift(t * t, 16);
      tcu  = round_shift(tsq * t, 16);
      o1 = p5 * (64'sd1 <<< 19) + round_shift(p6 * t, 6) + round_shift(p7 * tsq, 8)
         + round_shift(p8 * tcu, 15);
      c  = (p1 - 16384) * (64'sd1 <<< 20) + round_shift((p2 - 16384) * t, 5)
         + round_shift(p3 * tsq, 8) + round_shift(p4 * tcu, 13);
      o2 = round_shift(c * up, 24);
      q  = round_shift(round_shift((p9 * 65536 + p10 * t) * up, 20) * up, 28);
      k  = round_shift(round_shift(up * up * p11, 24) * up, 25);
      pout = clip(round_shift(o1 + o2 + q + k, WORK_FRAC - PRESS_FRAC_BITS), 0, U24_MAX,
                  hit);
      r.temperature_q16 = tout[23:0];
      r.pressure_q6     = pout[23:0];
      r.saturated       = hit;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("ERROR at %0t: reading %0d %s got 0x%0h want 0x%0h", $realtime,
               readings_checked, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_payload, 0);
         end else begin
            want = expected_readings.pop_front();
            if (rsp_payload.temperature_q16 !== want.temperature_q16)
               report_mismatch("temperature", rsp_payload.temperature_q16,
                               want.temperature_q16);
            if (rsp_payload.pressure_q6 !== want.pressure_q6)
               report_mismatch("pressure", rsp_payload.pressure_q6, want.pressure_q6);
            if (rsp_payload.saturated !== want.saturated)
               report_mismatch("saturated", rsp_payload.saturated, want.saturated);
            if (want.saturated) saturated_seen++;
         end
         readings_checked++;
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(20, 120);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 2) == 0);
            end
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic send_reading(input logic [23:0] pressure, input logic [23:0] temperature);
      req_type rd;
      int      gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      burst_left--;
      rd.raw_pressure    = pressure;
      rd.raw_temperature = temperature;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= rd;
      do @(posedge clock); while (!req_ready);
      expected_readings.push_back(compensate(rd));
      readings_sent++;
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_calib(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_CALIB_LOW:  calib_low  = value;
         REG_CALIB_MID:  calib_mid  = value;
         REG_CALIB_HIGH: calib_high = value[39:0];
         default: ;
      endcase
   endtask

   task automatic load_calib(input logic [63:0] lo, input logic [63:0] mid,
                             input logic [63:0] hi);
      drain();
      write_calib(REG_CALIB_LOW, lo);
      write_calib(REG_CALIB_MID, mid);
      write_calib(REG_CALIB_HIGH, hi);
      calib_loads++;
   endtask

   function automatic logic [63:0] rand64;
      return {$urandom, $urandom};
   endfunction

   // T1=27470 T2=19000 T3=-7 P1=-1400 P2=4341 P3=35 P4=-2 P5=24000 P6=30500
   // P7=-3 P8=-6 P9=16000 P10=5 P11=-60
   task automatic load_typical;
      load_calib({8'hF5, 8'hFA, 8'h88, 8'hF9, 8'h4A, 8'h38, 8'h6B, 8'h4E},
                 {8'hFD, 8'h77, 8'h24, 8'h5D, 8'hC0, 8'hFE, 8'h23, 8'h10},
                 {24'h0, 8'hC4, 8'h05, 8'h3E, 8'h80, 8'hFA});
   endtask

   task automatic test_uncalibrated;
      send_reading(24'h000000, 24'h000000);
      send_reading(24'hFFFFFF, 24'hFFFFFF);
      send_reading(24'h6B4E00, 24'h800000);
      send_reading(24'h7FFFFF, 24'h000001);
   endtask

   task automatic test_typical_extremes;
      load_typical();
      send_reading(24'h000000, 24'h000000);
      send_reading(24'hFFFFFF, 24'hFFFFFF);
      send_reading(24'h000000, 24'hFFFFFF);
      send_reading(24'hFFFFFF, 24'h000000);
      send_reading(24'h6B4E00, 24'h6B4E00);
      send_reading(24'h6E0000, 24'h7F0000);
      send_reading(24'h555555, 24'hAAAAAA);
      send_reading(24'hAAAAAA, 24'h555555);
   endtask

   task automatic test_extreme_calib;
      load_calib('1, '1, '1);
      send_reading(24'h000000, 24'h000000);
      send_reading(24'hFFFFFF, 24'hFFFFFF);
      send_reading(24'h800000, 24'h7FFFFF);
      load_calib({16'h0, 8'h7F, 16'h7FFF, 8'h7F, 16'hFFFF},
                 {8'h7F, 16'hFFFF, 16'hFFFF, 8'h7F, 8'h7F, 8'h7F},
                 {24'h0, 8'h7F, 8'h7F, 16'h7FFF, 8'h7F});
      send_reading(24'hFFFFFF, 24'h000000);
      send_reading(24'hFFFFFF, 24'hFFFFFF);
      load_calib({8'h80, 16'h8000, 8'h80, 32'h0}, {8'h80, 24'h0, 8'h80, 8'h80, 16'h8000},
                 {24'h0, 8'h80, 8'h80, 16'h8000, 8'h80});
      send_reading(24'hFFFFFF, 24'hFFFFFF);
      send_reading(24'h123456, 24'h000000);
   endtask

   task automatic test_random_calib;
      for (int phase = 0; phase < 6; phase++) begin
         if (phase % 2 == 0) load_calib(rand64(), rand64(), rand64());
         else load_calib(calib_low ^ {24'h0, 8'($urandom_range(0, 255)), 32'h0},
                         calib_mid ^ {48'h0, 16'($urandom_range(0, 65535))}, rand64());
         repeat (60) send_reading(24'($urandom), 24'($urandom));
      end
   endtask

   task automatic test_typical_random;
      for (int phase = 0; phase < 4; phase++) begin
         load_typical();
         repeat (200) send_reading(24'($urandom_range(24'h500000, 24'h7FFFFF)),
                                   24'($urandom_range(24'h600000, 24'h8FFFFF)));
         repeat (50) send_reading(24'($urandom), 24'($urandom));
      end
   endtask

   task automatic test_backpressure;
      load_typical();
      hold_cycles = 300;
      repeat (80) send_reading(24'($urandom), 24'($urandom));
      drain();
      repeat (40) send_reading(24'($urandom), 24'($urandom));
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      rsp_ready   = 1'b0;
      psel        = 1'b0;
      penable     = 1'b0;
      pwrite      = 1'b0;
      paddr       = '0;
      pwdata      = '0;
      calib_low   = '0;
      calib_mid   = '0;
      calib_high  = '0;
      mismatch_count   = 0;
      readings_sent    = 0;
      readings_checked = 0;
      saturated_seen   = 0;
      calib_loads      = 0;
      cycle_count      = 0;
      burst_left       = 0;
      hold_cycles      = 0;
      stall_mode       = 0;
      stall_left       = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_uncalibrated();
      test_typical_extremes();
      test_extreme_calib();
      test_backpressure();
      test_random_calib();
      test_typical_random();
      drain();

      $display("Covered %0d readings (%0d saturated) over %0d calibration loads,",
               readings_checked, saturated_seen, calib_loads);
      $display("with random gaps, result stalls and one long result hold-off.");
      if (mismatch_count == 0 && expected_readings.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
